@@ sv/lfd_pkg.sv @@
`default_nettype none
package lfd_pkg;

  localparam int unsigned FrameLen = 21;
  localparam int unsigned PosW     = $clog2(FrameLen);

  localparam logic [PosW-1:0] POS_FIRST = '0;
  localparam logic [PosW-1:0] POS_LAST  = PosW'(FrameLen - 1);
  localparam logic [PosW-1:0] POS_SUM_LO  = PosW'(1);
  localparam logic [PosW-1:0] POS_SUM_HI  = PosW'(17);
  localparam logic [PosW-1:0] POS_SUM_XTR = PosW'(19);

  localparam logic [7:0] SYNC_BYTE = 8'hE0;
  localparam logic [7:0] TAIL_BYTE = 8'hEB;
  localparam logic [7:0] LEN_BYTE  = 8'(FrameLen);

  localparam logic [7:0] REC_FUNCTION   = 8'h00;
  localparam logic [7:0] REC_TIMING     = 8'h1B;
  localparam logic [7:0] REC_FINAL      = 8'h1C;
  localparam logic [7:0] REC_BY_TIME    = 8'h3A;
  localparam logic [7:0] REC_LAPS_TOTAL = 8'h3B;
  localparam logic [7:0] REC_LAPS_INDIV = 8'h3C;
  localparam logic [7:0] REC_F1         = 8'h3D;

  localparam logic [7:0] FUNC_FIRST = 8'hA1;
  localparam logic [7:0] FUNC_LAST  = 8'hA7;
  localparam logic [7:0] FAST_LO    = 8'hA8;
  localparam logic [7:0] FAST_HI    = 8'hA9;

  typedef enum logic [2:0] {
    KIND_FUNCTION   = 3'd0,
    KIND_TIMING     = 3'd1,
    KIND_FINAL      = 3'd2,
    KIND_BY_TIME    = 3'd3,
    KIND_LAPS_TOTAL = 3'd4,
    KIND_LAPS_INDIV = 3'd5,
    KIND_F1         = 3'd6,
    KIND_UNKNOWN    = 3'd7
  } kind_t;

  localparam logic [2:0] FUNC_UNKNOWN = 3'd7;

  localparam int unsigned ERR_CHECKSUM = 0;
  localparam int unsigned ERR_LENGTH   = 1;
  localparam int unsigned ERR_TAIL     = 2;

  typedef logic [FrameLen-1:0][7:0] frame_t;

  typedef struct packed {
    logic            emit;
    logic            last;
  } trk_status_t;

  typedef struct packed {
    logic [2:0]  error_flags;
    logic [39:0] time_bcd;
    logic [14:0] laps;
    logic [15:0] program_values;
    logic [3:0]  lane;
    logic        fast_lap;
    logic        is_start_frame;
    logic [2:0]  function_kind;
    logic [7:0]  record_byte;
    kind_t       record_kind;
    logic [7:0]  model_byte;
  } record_t;

endpackage
`default_nettype wire

@@ sv/lfd_track.sv @@
`default_nettype none
module lfd_track
  import lfd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        step,
  input  wire logic [7:0]  rx_byte,
  output trk_status_t      status,
  output frame_t           frame,
  output logic [7:0]       sum
);

  logic            sync_r, sync_nxt;
  logic [PosW-1:0] pos_r, pos_nxt;
  frame_t          store_r;
  logic            differs_r, differs_nxt;
  logic [7:0]      sum_r, sum_nxt;

  logic            take;
  logic [PosW-1:0] eff_pos;
  logic            diff_now;
  logic            in_sum;

  // Before sync only the start byte is taken, and it lands in slot zero.
  assign take     = sync_r || (rx_byte == SYNC_BYTE);
  assign eff_pos  = sync_r ? pos_r : POS_FIRST;
  assign diff_now = (store_r[eff_pos] != rx_byte);
  assign in_sum   = ((eff_pos >= POS_SUM_LO) && (eff_pos <= POS_SUM_HI)) ||
                    (eff_pos == POS_SUM_XTR);

  always_comb begin
    sync_nxt    = sync_r;
    pos_nxt     = pos_r;
    differs_nxt = differs_r;
    sum_nxt     = sum_r;
    if (take) begin
      sync_nxt    = 1'b1;
      differs_nxt = (eff_pos == POS_FIRST) ? diff_now : (differs_r | diff_now);
      if (eff_pos == POS_FIRST) begin
        sum_nxt = '0;
      end else if (in_sum) begin
        sum_nxt = sum_r + rx_byte;
      end
      pos_nxt = (eff_pos == POS_LAST) ? POS_FIRST : eff_pos + 1'b1;
    end
  end

  // Slots not yet reached in the current frame still hold the last complete frame,
  // which is also the last emitted one: a frame that gave no record equals it byte for byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r    <= 1'b0;
      pos_r     <= POS_FIRST;
      differs_r <= 1'b0;
      sum_r     <= '0;
      store_r   <= '0;
    end else if (step) begin
      sync_r    <= sync_nxt;
      pos_r     <= pos_nxt;
      differs_r <= differs_nxt;
      sum_r     <= sum_nxt;
      if (take) begin
        store_r[eff_pos] <= rx_byte;
      end
    end
  end

  always_comb begin
    frame           = store_r;
    frame[POS_LAST] = rx_byte;
  end

  assign sum         = sum_r;
  assign status.last = take && (eff_pos == POS_LAST);
  assign status.emit = status.last && differs_nxt;

endmodule
`default_nettype wire

@@ sv/lfd_decode.sv @@
`default_nettype none
module lfd_decode
  import lfd_pkg::*;
(
  input  wire frame_t      frame,
  input  wire logic [7:0]  sum,
  output record_t          rec
);

  logic [7:0] b7, b8, b9, b10, b11, b12;
  kind_t      kind;
  logic       start;
  logic [3:0] lane_dec;

  assign b7  = frame[7];
  assign b8  = frame[8];
  assign b9  = frame[9];
  assign b10 = frame[10];
  assign b11 = frame[11];
  assign b12 = frame[12];

  always_comb begin
    case (b7)
      REC_FUNCTION:   kind = KIND_FUNCTION;
      REC_TIMING:     kind = KIND_TIMING;
      REC_FINAL:      kind = KIND_FINAL;
      REC_BY_TIME:    kind = KIND_BY_TIME;
      REC_LAPS_TOTAL: kind = KIND_LAPS_TOTAL;
      REC_LAPS_INDIV: kind = KIND_LAPS_INDIV;
      REC_F1:         kind = KIND_F1;
      default:        kind = KIND_UNKNOWN;
    endcase
  end

  // Lane byte is one-hot with the top bit meaning lane one.
  always_comb begin
    case (b10)
      8'h80:   lane_dec = 4'd1;
      8'h40:   lane_dec = 4'd2;
      8'h20:   lane_dec = 4'd3;
      8'h10:   lane_dec = 4'd4;
      8'h08:   lane_dec = 4'd5;
      8'h04:   lane_dec = 4'd6;
      8'h02:   lane_dec = 4'd7;
      8'h01:   lane_dec = 4'd8;
      default: lane_dec = 4'd0;
    endcase
  end

  assign start = (b8 == FUNC_FIRST);

  always_comb begin
    rec.model_byte     = frame[3];
    rec.record_kind    = kind;
    rec.record_byte    = b7;
    if ((kind == KIND_FUNCTION) && (b8 inside {[FUNC_FIRST:FUNC_LAST]})) begin
      rec.function_kind = 3'(b8 - FUNC_FIRST);
    end else begin
      rec.function_kind = FUNC_UNKNOWN;
    end
    rec.is_start_frame = start;
    rec.fast_lap       = !start && ((b9 == FAST_LO) || (b9 == FAST_HI));
    rec.lane           = (!start && (b7 != REC_FUNCTION)) ? lane_dec : 4'd0;
    rec.program_values = {b9, b10};
    rec.laps           = {11'd0, b11[7:4]} * 15'd1000 + {11'd0, b11[3:0]} * 15'd100
                       + {11'd0, b12[7:4]} * 15'd10 + {11'd0, b12[3:0]};
    rec.time_bcd       = {frame[13], frame[14], frame[15], frame[16], frame[17]};
    rec.error_flags[ERR_CHECKSUM] = (sum != frame[18]);
    rec.error_flags[ERR_LENGTH]   = (frame[2] != LEN_BYTE);
    rec.error_flags[ERR_TAIL]     = (frame[20] != TAIL_BYTE);
  end

endmodule
`default_nettype wire

@@ sv/lap_timer_frame_decoder_core.sv @@
// Path: a byte that closes a changed frame moves from the input register through the frame
// tracker, and its record is registered in the output register, from which it is presented.
// Throughput: one byte per cycle; the input register and frame tracker advance together, and
// only a changed frame end meeting a full, stalled output stops the input.
// Reset: synchronous, active low; sync is lost, the byte position returns to zero and the frame
// history is cleared to zeros, so the first frame differs from it and always gives a record.
`default_nettype none
module lap_timer_frame_decoder_core
  import lfd_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [7:0]   in_tdata,   // [7:0] rx_byte
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // [7:0] model_byte, [15:8] record_byte, [16] fast_lap, [20:17] lane,
  // [36:21] program_values, [51:37] laps, [91:52] time_bcd, [94:92] error_flags,
  // [95] zero fill
  output logic [95:0]       out_tdata,
  // [2:0] record_kind, [5:3] function_kind, [6] is_start_frame, [7] zero fill
  output logic [7:0]        out_tuser
);

  // Input register: one received byte waiting to be folded into the frame.
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;

  // Output register: one decoded record waiting for the consumer.
  logic       out_valid_r;
  record_t    out_rec_r;

  trk_status_t status;
  frame_t      frame;
  logic [7:0]  sum;
  record_t     rec;
  logic        out_free;
  logic        advance;

  // The held byte moves on unless it closes a changed frame while the
  // output register is still occupied by a record nobody has taken.
  assign out_free  = !out_valid_r || out_tready;
  assign advance   = s1_valid_r && (!status.emit || out_free);
  assign in_tready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
    end
  end

  // Sync search, byte position, frame history, change detection and checksum.
  lfd_track u_track (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .rx_byte (s1_byte_r),
    .status  (status),
    .frame   (frame),
    .sum     (sum)
  );

  // Field extraction of the completed frame; only sampled at a frame end.
  lfd_decode u_decode (
    .frame (frame),
    .sum   (sum),
    .rec   (rec)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && status.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && status.emit) begin
      out_rec_r <= rec;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_rec_r.error_flags, out_rec_r.time_bcd, out_rec_r.laps,
                       out_rec_r.program_values, out_rec_r.lane, out_rec_r.fast_lap,
                       out_rec_r.record_byte, out_rec_r.model_byte};
  assign out_tuser  = {1'b0, out_rec_r.is_start_frame, out_rec_r.function_kind,
                       out_rec_r.record_kind};

  // A record is only produced by the byte in the last slot of a frame.
  a_emit_at_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && status.emit) |-> status.last)
    else $error("record produced away from a frame end");

  // A changed frame end blocked by a full output keeps its byte in place.
  a_stall_holds_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && status.emit && out_valid_r && !out_tready) |=>
      (s1_valid_r && $stable(s1_byte_r)))
    else $error("stalled frame end byte was lost");

  // A new record appears only after the tracker advanced on a frame end.
  a_record_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(advance && status.emit))
    else $error("record appeared without a frame end");

endmodule
`default_nettype wire
